@@ sv/pmc_pkg.sv @@
package pmc_pkg;

    localparam int NUM_BUTTONS = 14;

    // button bit positions
    localparam int BTN_FWD   = 0;
    localparam int BTN_THR   = 1;
    localparam int BTN_MODE  = 2;
    localparam int BTN_UP    = 3;
    localparam int BTN_REF   = 4;
    localparam int BTN_AST   = 5;
    localparam int BTN_RIGHT = 6;
    localparam int BTN_ATGT  = 7;
    localparam int BTN_DOWN  = 8;
    localparam int BTN_TTGT  = 9;
    localparam int BTN_LEFT  = 10;
    localparam int BTN_BWD   = 11;
    localparam int BTN_NODE  = 12;
    localparam int BTN_HOLD  = 13;

    // command characters
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_Q = 8'h51;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_W = 8'h57;

    // speed reference codes
    localparam logic [1:0] REF_ORBIT   = 2'd0;
    localparam logic [1:0] REF_TARGET  = 2'd1;
    localparam logic [1:0] REF_SURFACE = 2'd2;

    // assist mode codes
    localparam logic [3:0] AM_HOLD    = 4'd0;
    localparam logic [3:0] AM_PRO     = 4'd1;
    localparam logic [3:0] AM_RETRO   = 4'd2;
    localparam logic [3:0] AM_NORM    = 4'd3;
    localparam logic [3:0] AM_ANORM   = 4'd4;
    localparam logic [3:0] AM_RAD     = 4'd5;
    localparam logic [3:0] AM_ARAD    = 4'd6;
    localparam logic [3:0] AM_NODE    = 4'd7;
    localparam logic [3:0] AM_TTGT    = 4'd8;
    localparam logic [3:0] AM_ATGT    = 4'd9;

    typedef struct packed {
        logic                   assist;
        logic                   thrust;
        logic                   mode;
        logic [1:0]             speed;
        logic [3:0]             asel;
        logic [5:0]             move;
        logic [NUM_BUTTONS-1:0] prev;
        logic [13:0]            last_rep;
        logic                   rep_valid;
    } pmc_state_t;

    localparam pmc_state_t STATE_RESET = '{
        assist:    1'b0,
        thrust:    1'b0,
        mode:      1'b0,
        speed:     REF_SURFACE,
        asel:      AM_HOLD,
        move:      6'd0,
        prev:      '0,
        last_rep:  14'd0,
        rep_valid: 1'b0
    };

    typedef struct packed {
        logic       changed;
        logic [5:0] translation;
        logic [3:0] assist_mode;
        logic [1:0] speed_reference;
        logic       panel_mode;
        logic       thrust_on;
        logic       assist_on;
        logic       hold_lamp;
        logic [15:0] led_word;
    } pmc_result_t;

    localparam int RESULT_W = $bits(pmc_result_t);
    localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

    // lamp mask for an assist mode; hold and unknown codes light nothing here
    function automatic logic [15:0] assist_lamp(input logic [3:0] am);
        logic [15:0] m;
        m = 16'd0;
        unique case (am)
            AM_PRO:   m[0]  = 1'b1;
            AM_RETRO: m[7]  = 1'b1;
            AM_NORM:  m[12] = 1'b1;
            AM_ANORM: m[3]  = 1'b1;
            AM_RAD:   m[6]  = 1'b1;
            AM_ARAD:  m[5]  = 1'b1;
            AM_NODE:  m[1]  = 1'b1;
            AM_TTGT:  m[2]  = 1'b1;
            AM_ATGT:  m[4]  = 1'b1;
            default:  m     = 16'd0;
        endcase
        return m;
    endfunction

endpackage

@@ sv/panel_mode_controller_core.sv @@
// Front-panel mode controller. Takes one word per clock on s_* while s_tready
// is high: a command character (s_tuser = 0) updates the panel state and
// yields no output word; a scan (s_tuser = 1) yields one output word with
// the lamp pattern and the reported state. A scan passes the input register,
// then the state update into the output register; m_tready low stalls the
// input side only once a scan waits behind a full output register.
module panel_mode_controller_core
    import pmc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // rx_byte[7:0], buttons[21:8], zero pad
    input  logic                   s_tuser,   // cmd
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata    // led_word, hold_lamp, assist_on, thrust_on,
                                              // panel_mode, speed_reference, assist_mode,
                                              // translation, report_changed, zero pad
);

    logic                   in_valid_reg;
    logic                   in_cmd_reg;
    logic [7:0]             in_byte_reg;
    logic [NUM_BUTTONS-1:0] in_btn_reg;
    pmc_state_t             state_reg;
    pmc_state_t             state_next;
    pmc_result_t            res;
    logic                   out_valid_reg;
    pmc_result_t            out_data_reg;
    logic                   out_free;
    logic                   advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_cmd_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    pmc_step u_step (
        .cur     (state_reg),
        .cmd     (in_cmd_reg),
        .rx_byte (in_byte_reg),
        .buttons (in_btn_reg),
        .nxt     (state_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_cmd_reg    <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                in_cmd_reg   <= s_tuser;
            end
            if (advance)
                state_reg <= state_next;
            if (advance && in_cmd_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata[7:0];
            in_btn_reg  <= s_tdata[21:8];
        end
        if (advance && in_cmd_reg)
            out_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W-RESULT_W){1'b0}}, out_data_reg};

endmodule

@@ sv/pmc_step.sv @@
module pmc_step
    import pmc_pkg::*;
(
    input  pmc_state_t              cur,
    input  logic                    cmd,
    input  logic [7:0]              rx_byte,
    input  logic [NUM_BUTTONS-1:0]  buttons,
    output pmc_state_t              nxt,
    output pmc_result_t             res
);

    always_comb
    begin
        logic [NUM_BUTTONS-1:0] rise;
        logic [15:0]            led;
        logic                   hold;
        logic [7:0]             off;
        logic [13:0]            rep;
        logic                   chg;
        pmc_state_t             s;

        s    = cur;
        led  = 16'd0;
        hold = 1'b0;
        rise = buttons & ~cur.prev;
        off  = 8'd0;
        rep  = 14'd0;
        chg  = 1'b0;

        if (!cmd)
        begin
            priority if (rx_byte == CH_A)
                s.assist = 1'b1;
            else if (rx_byte == CH_B)
                s.assist = 1'b0;
            else if (rx_byte == CH_C)
                s.thrust = 1'b1;
            else if (rx_byte == CH_D)
                s.thrust = 1'b0;
            else if (rx_byte >= CH_E && rx_byte <= CH_G)
            begin
                off     = rx_byte - CH_E;
                s.speed = off[1:0];
            end
            else if (rx_byte >= CH_H && rx_byte <= CH_M)
            begin
                off    = rx_byte - CH_H;
                s.asel = off[3:0] + AM_PRO;
            end
            else if (rx_byte == CH_N)
                s.asel = AM_HOLD;
            else if (rx_byte >= CH_O && rx_byte <= CH_Q)
            begin
                off    = rx_byte - CH_O;
                s.asel = off[3:0] + AM_NODE;
            end
            else if (rx_byte >= CH_R && rx_byte <= CH_W)
            begin
                off    = rx_byte - CH_R;
                s.move = cur.move | (6'd1 << off[2:0]);
            end
            else
                s = cur;    // unknown character
        end
        else
        begin
            // lamps from the state before this scan
            led[8]  = cur.thrust;
            led[11] = cur.assist;
            led[9]  = cur.mode;
            led[10] = !cur.mode;
            unique case (cur.speed)
                REF_ORBIT:   led[13] = 1'b1;
                REF_TARGET:  led[14] = 1'b1;
                REF_SURFACE: led[15] = 1'b1;
                default:     led[15] = 1'b0;
            endcase
            if (cur.assist && !cur.mode)
            begin
                hold = (cur.asel == AM_HOLD);
                led  = led | assist_lamp(cur.asel);
            end
            else
            begin
                priority if (cur.prev[BTN_UP])
                    led[12] = 1'b1;
                else if (cur.prev[BTN_DOWN])
                    led[3] = 1'b1;
                else if (cur.prev[BTN_LEFT])
                    led[6] = 1'b1;
                else if (cur.prev[BTN_RIGHT])
                    led[5] = 1'b1;
                else if (cur.prev[BTN_FWD])
                    led[0] = 1'b1;
                else if (cur.prev[BTN_BWD])
                    led[7] = 1'b1;
                else
                    led[0] = 1'b0;  // no direction held
            end

            // button actions
            s.thrust = cur.thrust ^ rise[BTN_THR];
            s.assist = cur.assist ^ rise[BTN_AST];
            s.mode   = cur.mode ^ rise[BTN_MODE];
            if (rise[BTN_REF])
                s.speed = (cur.speed >= REF_SURFACE) ? REF_ORBIT : cur.speed + 2'd1;
            if (!s.mode)
            begin
                // last pick wins; within one scan the first match below has priority
                priority if (rise[BTN_ATGT])
                    s.asel = AM_ATGT;
                else if (rise[BTN_TTGT])
                    s.asel = AM_TTGT;
                else if (rise[BTN_NODE])
                    s.asel = AM_NODE;
                else if (rise[BTN_HOLD])
                    s.asel = AM_HOLD;
                else if (rise[BTN_RIGHT])
                    s.asel = AM_ARAD;
                else if (rise[BTN_LEFT])
                    s.asel = AM_RAD;
                else if (rise[BTN_DOWN])
                    s.asel = AM_ANORM;
                else if (rise[BTN_UP])
                    s.asel = AM_NORM;
                else if (rise[BTN_BWD])
                    s.asel = AM_RETRO;
                else if (rise[BTN_FWD])
                    s.asel = AM_PRO;
                else
                    s.asel = cur.asel;
            end
            else
            begin
                s.move = {buttons[BTN_RIGHT], buttons[BTN_LEFT], buttons[BTN_DOWN],
                          buttons[BTN_UP], buttons[BTN_BWD], buttons[BTN_FWD]};
            end
            s.prev = buttons;

            rep = {s.move, s.asel, s.speed, s.thrust, s.assist};
            chg         = !cur.rep_valid || (rep != cur.last_rep);
            s.last_rep  = rep;
            s.rep_valid = 1'b1;
        end

        res.led_word        = led;
        res.hold_lamp       = hold;
        res.assist_on       = s.assist;
        res.thrust_on       = s.thrust;
        res.panel_mode      = s.mode;
        res.speed_reference = s.speed;
        res.assist_mode     = s.asel;
        res.translation     = s.move;
        res.changed         = chg;

        if (cmd)
            s.move = 6'd0;
        nxt = s;
    end

endmodule

@@ sv/pmc_checker.sv @@
module pmc_checker
    import pmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [23:0]      s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_speed_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[21:20] != 2'd3)
        else $error("speed reference out of range");

    a_assist_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:22] <= AM_ATGT)
        else $error("assist mode out of range");

    a_mode_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[9] != m_tdata[10])
        else $error("panel mode lamps not exclusive");

endmodule

bind panel_mode_controller_core pmc_checker u_pmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
